// ----- design/mpo_pkg.sv -----
// Package for the morphing phase oscillator.
// Holds the sine polynomial coefficients, the wave pair tables and shared types.
// No dependencies.
`default_nettype none

package mpo_pkg;

    localparam int PhaseW = 32;
    localparam int MulAW = 40;
    localparam int MulBW = 32;
    localparam int DigitW = 4;
    localparam int MulDigits = MulBW / DigitW;
    localparam int AccW = MulAW + MulBW;
    localparam int SampleW = 15;

    localparam logic signed [MulAW-1:0] COS_C0 = 40'sd19740964;
    localparam logic signed [MulAW-1:0] COS_C1 = -40'sd28002488;
    localparam logic signed [MulAW-1:0] COS_C2 = 40'sd21279341;
    localparam logic signed [MulAW-1:0] COS_C3 = -40'sd6468144;
    localparam logic signed [MulAW-1:0] SIN_C0 = -40'sd25134976;
    localparam logic signed [MulAW-1:0] SIN_C1 = 40'sd26740408;
    localparam logic signed [MulAW-1:0] SIN_C2 = -40'sd13546849;
    localparam logic signed [MulAW-1:0] SIN_C3 = 40'sd2058874;
    localparam logic signed [MulAW-1:0] FIVE_V = 40'sd327680;

    localparam logic [2:0] WAVE_SINE = 3'd0;
    localparam logic [2:0] WAVE_HALF = 3'd1;
    localparam logic [2:0] WAVE_SAW = 3'd2;
    localparam logic [2:0] WAVE_TRI = 3'd3;
    localparam logic [2:0] WAVE_SQUARE = 3'd4;

    typedef struct packed {
        logic start;
        logic signed [MulAW-1:0] a;
        logic [MulBW-1:0] b_mag;
        logic b_neg;
    } mpo_mul_req_t;

    function automatic logic [2:0] pick_a(input logic [3:0] kind);
        logic [2:0] w;
        case (kind)
            4'd0: w = WAVE_SINE;
            4'd1: w = WAVE_SAW;
            4'd2: w = WAVE_HALF;
            4'd3: w = WAVE_TRI;
            4'd4: w = WAVE_SQUARE;
            4'd5: w = WAVE_SINE;
            4'd6: w = WAVE_TRI;
            4'd7: w = WAVE_SAW;
            4'd8: w = WAVE_SQUARE;
            4'd9: w = WAVE_HALF;
            default: w = WAVE_SINE;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] pick_b(input logic [3:0] kind);
        logic [2:0] w;
        case (kind)
            4'd0: w = WAVE_SAW;
            4'd1: w = WAVE_HALF;
            4'd2: w = WAVE_TRI;
            4'd3: w = WAVE_SQUARE;
            4'd4: w = WAVE_SINE;
            4'd5: w = WAVE_TRI;
            4'd6: w = WAVE_SAW;
            4'd7: w = WAVE_SQUARE;
            4'd8: w = WAVE_HALF;
            4'd9: w = WAVE_SINE;
            default: w = WAVE_SINE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/mpo_op_if.sv -----
// Request channel of the morphing phase oscillator.
// Carries valid, ready and the operator fields; no dependencies.
`default_nettype none

interface mpo_op_if;
    logic valid;
    logic ready;
    logic advance;
    logic [31:0] phase_step;
    logic [14:0] wave_knob;
    logic signed [15:0] wave_cv;
    logic [4:0] mult_knob;
    logic signed [15:0] mult_cv;
    logic signed [16:0] phase_knob;
    logic signed [15:0] phase_cv;

    modport source (output valid, advance, phase_step, wave_knob, wave_cv, mult_knob,
        mult_cv, phase_knob, phase_cv, input ready);
    modport sink (input valid, advance, phase_step, wave_knob, wave_cv, mult_knob,
        mult_cv, phase_knob, phase_cv, output ready);
endinterface

`default_nettype wire

// ----- design/mpo_res_if.sv -----
// Result channel of the morphing phase oscillator.
// Carries valid, ready and the output sample; no dependencies.
`default_nettype none

interface mpo_res_if;
    logic valid;
    logic ready;
    logic signed [14:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

`default_nettype wire

// ----- design/morphing_phase_oscillator.sv -----
// Top level of the morphing phase oscillator: phase accumulator, multiplier,
// sine polynomial sequencer and wave crossfade. Uses mpo_pkg, mpo_op_if,
// mpo_res_if and mpo_serial_mult.
//
//   port  dir  fields
//   op    in   advance, phase_step, wave_knob, wave_cv, mult_knob, mult_cv,
//              phase_knob, phase_cv
//   res   out  sample
//
// One request at a time; a result appears after five passes through the shared
// multiplier, each made of an issue, a digit-serial multiply and a collect.
// Reset clears base_phase and all control state.
// A stalled result holds in its output register; the next request is taken
// as soon as the sequencer is back in idle, even while the result waits.
`default_nettype none

module morphing_phase_oscillator
    import mpo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpo_op_if.sink    op,
    mpo_res_if.source res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PH = 3'd1;
    localparam logic [2:0] S_MOD = 3'd2;
    localparam logic [2:0] S_POLY = 3'd3;
    localparam logic [2:0] S_MUL = 3'd4;
    localparam logic [2:0] S_WAVE = 3'd5;
    localparam logic [2:0] S_MIX = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    logic [2:0] state_reg;
    logic [PhaseW-1:0] base_reg;
    logic [2:0] k_reg;
    logic res_valid_reg;
    logic signed [SampleW-1:0] sample_reg;

    logic [14:0] wave_knob_reg;
    logic signed [15:0] wave_cv_reg;
    logic [4:0] mult_knob_reg;
    logic signed [15:0] mult_cv_reg;
    logic signed [16:0] phase_knob_reg;
    logic signed [15:0] phase_cv_reg;

    logic [PhaseW-1:0] off_reg;
    logic [4:0] m_reg;
    logic [3:0] type_reg;
    logic [10:0] f_reg;
    logic [PhaseW-1:0] o_reg;
    logic signed [32:0] r_reg;
    logic cos_reg;
    logic flip_reg;
    logic [MulBW-1:0] z_reg;
    logic signed [MulAW-1:0] y_reg;
    logic signed [30:0] pa_reg;
    logic signed [30:0] pb_reg;
    logic signed [SampleW-1:0] mix_reg;

    mpo_mul_req_t mul_req;
    logic mul_done;
    logic signed [MulAW-1:0] mul_res;

    logic op_accept;
    logic signed [16:0] pcv_x;
    logic [16:0] pmag;
    logic [PhaseW-1:0] cv_hi;
    logic [18:0] cv_v;
    logic [36:0] cv_lo_full;
    logic [PhaseW-1:0] cv_pos;
    logic [PhaseW-1:0] cv_term;
    logic [PhaseW-1:0] off_now;
    logic signed [20:0] msum;
    logic [6:0] mq;
    logic [13:0] mq_prod;
    logic [4:0] m_now;
    logic signed [17:0] w_sum;
    logic [14:0] w_clamp;

    logic [36:0] om_full;
    logic [PhaseW-1:0] o_now;
    logic [3:0] j_now;
    logic signed [34:0] r_full;
    logic [32:0] r_abs;

    logic signed [MulAW-1:0] ys;
    logic signed [17:0] sine;
    logic signed [17:0] sine_abs;
    logic signed [17:0] half;
    logic [47:0] saw_full;
    logic signed [17:0] saw;
    logic [47:0] tri_full;
    logic signed [17:0] tri_d1;
    logic signed [17:0] tri_d2;
    logic signed [17:0] tri_v;
    logic signed [17:0] square;
    logic signed [17:0] wave_a;
    logic signed [17:0] wave_b;
    logic signed [12:0] wgt_b;
    logic signed [12:0] wgt_a;
    logic signed [31:0] mix_sum;
    logic signed [31:0] mix_sh;
    logic signed [MulAW-1:0] c_next;

    assign op_accept = op.valid && op.ready;
    assign op.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.sample = sample_reg;

    // Phase offset and multiplier.
    assign pcv_x = {phase_cv_reg[15], phase_cv_reg};
    assign pmag = pcv_x[16] ? 17'(-pcv_x) : 17'(pcv_x);
    assign cv_hi = 32'(37'(pmag) * 37'd838860);
    assign cv_v = {pmag, 2'b00} + 19'd2;
    assign cv_lo_full = 37'(cv_v) * 37'd209716;
    assign cv_pos = cv_hi + 32'(cv_lo_full[36:20]);
    assign cv_term = pcv_x[16] ? -cv_pos : cv_pos;
    assign off_now = base_reg + {phase_knob_reg[14:0], 17'b0} + cv_term;

    assign msum = $signed(21'(mult_knob_reg) * 21'sd10240) + ($signed(21'(mult_cv_reg)) <<< 3);
    assign mq = msum[17:11];
    assign mq_prod = 14'(mq) * 14'd205;
    always_comb
    begin
        if (msum < 21'sd10240)
            m_now = 5'd1;
        else if (msum >= 21'sd163840)
            m_now = 5'd16;
        else
            m_now = {1'b0, mq_prod[13:10]};
    end

    assign w_sum = $signed({3'b000, wave_knob_reg}) + 18'(wave_cv_reg);
    always_comb
    begin
        if (w_sum < 18'sd0)
            w_clamp = 15'd0;
        else if (w_sum > 18'sd20480)
            w_clamp = 15'd20480;
        else
            w_clamp = w_sum[14:0];
    end

    // Multiplied phase and sine octant.
    assign om_full = 37'(off_reg) * 37'(m_reg);
    assign o_now = om_full[PhaseW-1:0];
    assign j_now = ({1'b0, o_now[31:29]} + 4'd1) & 4'b1110;
    assign r_full = $signed({3'b000, o_now}) - $signed({2'b00, j_now, 29'b0});
    assign r_abs = r_reg[32] ? 33'(-r_reg) : 33'(r_reg);

    always_comb
    begin
        mul_req.start = (state_reg == S_POLY);
        mul_req.a = y_reg;
        mul_req.b_mag = z_reg;
        mul_req.b_neg = 1'b0;
        if (k_reg == 3'd0 || (k_reg == 3'd4 && !cos_reg))
        begin
            mul_req.b_mag = r_abs[MulBW-1:0];
            mul_req.b_neg = r_reg[32];
        end
        if (k_reg == 3'd0)
            mul_req.a = MulAW'(r_reg);
    end

    always_comb
    begin
        case (k_reg)
            3'd1: c_next = cos_reg ? COS_C1 : SIN_C1;
            3'd2: c_next = cos_reg ? COS_C2 : SIN_C2;
            3'd3: c_next = cos_reg ? COS_C3 : SIN_C3;
            default: c_next = cos_reg ? FIVE_V : '0;
        endcase
    end

    // Waves.
    assign ys = (y_reg + MulAW'(16)) >>> 5;
    assign sine = flip_reg ? -ys[17:0] : ys[17:0];
    assign sine_abs = sine[17] ? -sine : sine;
    assign half = (sine_abs <<< 1) - 18'sd10240;
    assign saw_full = 48'(o_reg) * 48'd20480 + 48'h0000_8000_0000;
    assign saw = (o_reg > 32'h8000_0000) ? $signed({2'b00, saw_full[47:32]}) - 18'sd20480
        : $signed({2'b00, saw_full[47:32]});
    assign tri_full = 48'(o_reg) * 48'd40960 + 48'h0000_8000_0000;
    assign tri_d1 = $signed({2'b00, tri_full[47:32]}) - 18'sd10240;
    assign tri_d2 = (tri_d1[17] ? -tri_d1 : tri_d1) - 18'sd20480;
    assign tri_v = (tri_d2[17] ? -tri_d2 : tri_d2) - 18'sd10240;
    assign square = tri_v[17] ? -18'sd10240 : 18'sd10240;

    function automatic logic signed [17:0] wave_pick(input logic [2:0] kind,
        input logic signed [17:0] v_sine, input logic signed [17:0] v_half,
        input logic signed [17:0] v_saw, input logic signed [17:0] v_tri,
        input logic signed [17:0] v_sq);
        logic signed [17:0] v;
        case (kind)
            WAVE_SINE: v = v_sine;
            WAVE_HALF: v = v_half;
            WAVE_SAW: v = v_saw;
            WAVE_TRI: v = v_tri;
            WAVE_SQUARE: v = v_sq;
            default: v = v_sine;
        endcase
        return v;
    endfunction

    assign wave_a = wave_pick(pick_a(type_reg), sine, half, saw, tri_v, square);
    assign wave_b = wave_pick(pick_b(type_reg), sine, half, saw, tri_v, square);
    assign wgt_b = $signed({2'b00, f_reg});
    assign wgt_a = 13'sd2048 - wgt_b;

    assign mix_sum = 32'(pa_reg) + 32'(pb_reg) + 32'sd1024;
    assign mix_sh = mix_sum >>> 11;

    mpo_serial_mult u_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg <= '0;
            k_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (op_accept)
                    begin
                        if (op.advance)
                            base_reg <= base_reg + op.phase_step;
                        state_reg <= S_PH;
                    end
                end
                S_PH: state_reg <= S_MOD;
                S_MOD:
                begin
                    k_reg <= '0;
                    state_reg <= S_POLY;
                end
                S_POLY: state_reg <= S_MUL;
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        k_reg <= k_reg + 3'd1;
                        state_reg <= (k_reg == 3'd4) ? S_WAVE : S_POLY;
                    end
                end
                S_WAVE: state_reg <= S_MIX;
                S_MIX: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_accept)
        begin
            wave_knob_reg <= op.wave_knob;
            wave_cv_reg <= op.wave_cv;
            mult_knob_reg <= op.mult_knob;
            mult_cv_reg <= op.mult_cv;
            phase_knob_reg <= op.phase_knob;
            phase_cv_reg <= op.phase_cv;
        end
        if (state_reg == S_PH)
        begin
            off_reg <= off_now;
            m_reg <= m_now;
            type_reg <= w_clamp[14:11];
            f_reg <= w_clamp[10:0];
        end
        if (state_reg == S_MOD)
        begin
            o_reg <= o_now;
            r_reg <= r_full[32:0];
            cos_reg <= j_now[1];
            flip_reg <= j_now[2];
        end
        if (state_reg == S_MUL && mul_done)
        begin
            if (k_reg == 3'd0)
            begin
                z_reg <= mul_res[MulBW-1:0];
                y_reg <= cos_reg ? COS_C0 : SIN_C0;
            end
            else
                y_reg <= mul_res + c_next;
        end
        if (state_reg == S_WAVE)
        begin
            pa_reg <= 31'(wave_a * wgt_a);
            pb_reg <= 31'(wave_b * wgt_b);
        end
        if (state_reg == S_MIX)
        begin
            if (mix_sh > 32'sd10240)
                mix_reg <= 15'sd10240;
            else if (mix_sh < -32'sd10240)
                mix_reg <= -15'sd10240;
            else
                mix_reg <= mix_sh[SampleW-1:0];
        end
        if (state_reg == S_OUT && (!res_valid_reg || res.ready))
            sample_reg <= mix_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n) op_accept |=> state_reg == S_PH)
        else $error("accepted request did not start the sequence");
    assert property (@(posedge clk) disable iff (!rst_n) mul_done |-> state_reg == S_MUL)
        else $error("multiplier finished outside the wait state");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (sample_reg <= 15'sd10240 && sample_reg >= -15'sd10240))
        else $error("sample outside the five volt range");

endmodule

`default_nettype wire

// ----- design/mpo_serial_mult.sv -----
// Digit-serial signed multiplier, four bits of the magnitude operand per cycle.
// Returns the product shifted right by 32 with rounding half up. Uses mpo_pkg.
`default_nettype none

module mpo_serial_mult
    import mpo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire mpo_mul_req_t req,
    output logic done,
    output logic signed [MulAW-1:0] result
);

    logic signed [AccW-1:0] acc_reg, acc_next;
    logic signed [MulAW-1:0] a_reg;
    logic [MulBW-1:0] b_reg;
    logic neg_reg;
    logic busy_reg;
    logic done_reg;
    logic [$clog2(MulDigits)-1:0] cnt_reg;
    logic signed [MulAW+DigitW:0] pp;
    logic signed [AccW-1:0] prod;
    logic signed [AccW-1:0] rounded;

    assign pp = a_reg * $signed({1'b0, b_reg[MulBW-1 -: DigitW]});
    assign acc_next = (acc_reg <<< DigitW) + AccW'(pp);
    assign prod = neg_reg ? -acc_reg : acc_reg;
    assign rounded = (prod + (AccW'(1) <<< 31)) >>> 32;
    assign result = rounded[MulAW-1:0];
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == $clog2(MulDigits)'(MulDigits - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg <= req.a;
            b_reg <= req.b_mag;
            neg_reg <= req.b_neg;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg <= b_reg << DigitW;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_reg)
        else $error("multiplier did not start");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !req.start)
        else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

// ----- verif/mpo_checker.sv -----
`timescale 1ns / 100ps
// Checker for the morphing phase oscillator: predicts each sample from accepted
// requests and compares it with the result channel. Uses mpo_op_if and mpo_res_if.
`default_nettype none

module mpo_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    mpo_op_if         op,
    mpo_res_if        res,
    output int        errors,
    output int        pending,
    output int        accepted
);

    localparam logic [2:0] SINE = 3'd0;
    localparam logic [2:0] HALF = 3'd1;
    localparam logic [2:0] SAW = 3'd2;
    localparam logic [2:0] TRI = 3'd3;
    localparam logic [2:0] SQUARE = 3'd4;
    localparam longint FULL = 10240;

    logic [31:0] base_phase;
    logic signed [14:0] samples_due[$];
    logic [2:0] first_wave[11] = '{SINE, SAW, HALF, TRI, SQUARE, SINE, TRI, SAW, SQUARE,
        HALF, SINE};
    logic [2:0] second_wave[11] = '{SAW, HALF, TRI, SQUARE, SINE, TRI, SAW, SQUARE, HALF,
        SINE, SINE};
    longint cos_k[4] = '{19740964, -28002488, 21279341, -6468144};
    longint sin_k[4] = '{-25134976, 26740408, -13546849, 2058874};

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sine_of(logic [31:0] o);
        longint j, r, z, y;
        j = ((o >> 29) + 1) & 14;
        r = longint'(o) - (j << 29);
        z = rshift(r * r, 32);
        if (j & 2)
        begin
            y = cos_k[0];
            for (int i = 1; i < 4; i++)
                y = rshift(y * z, 32) + cos_k[i];
            y = rshift(y * z, 32) + (longint'(5) << 16);
        end
        else
        begin
            y = sin_k[0];
            for (int i = 1; i < 4; i++)
                y = rshift(y * z, 32) + sin_k[i];
            y = rshift(y * r, 32);
        end
        y = rshift(y, 5);
        return (j & 4) ? -y : y;
    endfunction

    function automatic longint wave_of(logic [2:0] kind, logic [31:0] o, longint sine);
        longint t;
        case (kind)
            SINE: return sine;
            HALF: return 2 * labs(sine) - FULL;
            SAW:
            begin
                t = (longint'(20480) * o + 64'h8000_0000) >> 32;
                return (o > 32'h8000_0000) ? t - 20480 : t;
            end
            default:
            begin
                t = (longint'(40960) * o + 64'h8000_0000) >> 32;
                t = labs(labs(t - FULL) - 20480) - FULL;
                if (kind == TRI)
                    return t;
                return t < 0 ? -FULL : FULL;
            end
        endcase
    endfunction

    function automatic logic signed [14:0] predict_sample(longint wknob, longint wcv,
        longint mknob, longint mcv, longint pknob, longint pcv);
        longint w, s, m, mix, cvterm, sine;
        logic [31:0] off;
        int kind;
        cvterm = ((labs(pcv) << 22) + 2) / 5;
        if (pcv < 0)
            cvterm = -cvterm;
        off = 32'(longint'(base_phase) + (pknob << 17) + cvterm);
        s = 10240 * mknob + 8 * mcv;
        m = s < 10240 ? 1 : (s >= 163840 ? 16 : s / 10240);
        off = 32'(longint'(off) * m);
        w = wknob + wcv;
        w = w < 0 ? 0 : (w > 20480 ? 20480 : w);
        kind = int'(w >> 11);
        sine = sine_of(off);
        mix = wave_of(first_wave[kind], off, sine) * (2048 - (w & 2047))
            + wave_of(second_wave[kind], off, sine) * (w & 2047);
        mix = (mix + 1024) >>> 11;
        mix = mix > FULL ? FULL : (mix < -FULL ? -FULL : mix);
        return 15'(mix);
    endfunction

    assign pending = samples_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_phase = '0;
            errors <= 0;
            accepted <= 0;
            samples_due.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (samples_due.size() == 0)
                begin
                    $display("%0t: unexpected sample %0d", $time, res.sample);
                    errors <= errors + 1;
                end
                else if (samples_due[0] !== res.sample)
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                        samples_due[0], res.sample);
                    errors <= errors + 1;
                    void'(samples_due.pop_front());
                end
                else
                    void'(samples_due.pop_front());
            end
            if (op.valid && op.ready)
            begin
                if (op.advance)
                    base_phase = base_phase + op.phase_step;
                samples_due.push_back(predict_sample(op.wave_knob, op.wave_cv, op.mult_knob,
                    op.mult_cv, op.phase_knob, op.phase_cv));
                accepted <= accepted + 1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_morphing_phase_oscillator.sv -----
`timescale 1ns / 100ps
// Testbench top for the morphing phase oscillator: drives requests and result
// stalls, and gives the verdict. Uses mpo_op_if, mpo_res_if, mpo_checker and the oscillator.
`default_nettype none

module tb_morphing_phase_oscillator;

    localparam int IdleLimit = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int errors, pending, accepted;
    int idle_cycles = 0;
    int stall_left = 0;
    bit stim_done = 1'b0;

    mpo_op_if op ();
    mpo_res_if res ();

    morphing_phase_oscillator dut (.clk(clk), .rst_n(rst_n), .op(op), .res(res));
    mpo_checker checker_i (.clk(clk), .rst_n(rst_n), .op(op), .res(res),
        .errors(errors), .pending(pending), .accepted(accepted));

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic send(logic adv, logic [31:0] step, logic [14:0] wk, logic signed [15:0] wcv,
        logic [4:0] mk, logic signed [15:0] mcv, logic signed [16:0] pk,
        logic signed [15:0] pcv);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            op.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        op.valid <= 1'b1;
        op.advance <= adv;
        op.phase_step <= step;
        op.wave_knob <= wk;
        op.wave_cv <= wcv;
        op.mult_knob <= mk;
        op.mult_cv <= mcv;
        op.phase_knob <= pk;
        op.phase_cv <= pcv;
        @(posedge clk);
        while (!op.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [14:0] wk;
        if ($urandom_range(0, 9) < 7)
            wk = 15'($urandom_range(0, 20480));
        else
            wk = 15'($urandom);
        send(1'($urandom_range(0, 1)), $urandom, wk, 16'($urandom), 5'($urandom),
            ($urandom_range(0, 1) ? 16'($urandom_range(0, 40960) - 20480) : 16'($urandom)),
            17'($urandom), 16'($urandom));
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            res.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            res.ready <= 1'b0;
            stall_left = gap_len();
        end
        else
            res.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((op.valid && op.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && (!stim_done || pending != 0))
        begin
            $display("Watchdog: no handshake for %0d cycles", IdleLimit);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        op.valid = 1'b0;
        op.advance = 1'b0;
        op.phase_step = '0;
        op.wave_knob = '0;
        op.wave_cv = '0;
        op.mult_knob = '0;
        op.mult_cv = '0;
        op.phase_knob = '0;
        op.phase_cv = '0;
        res.ready = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        send(1'b0, 32'h0, 15'd0, 16'sd0, 5'd1, 16'sd0, 17'sd0, 16'sd0);
        send(1'b1, 32'hFFFF_FFFF, 15'd20480, 16'sd20480, 5'd16, 16'sd20480, 17'sd32767,
            16'sd20480);
        send(1'b1, 32'h8000_0000, 15'h7FFF, -16'sd32768, 5'd0, -16'sd32768, -17'sd65536,
            -16'sd32768);
        send(1'b1, 32'h1234_5678, 15'd0, -16'sd20480, 5'd31, 16'sd32767, 17'sd65535,
            16'sd32767);
        for (int k = 0; k <= 10; k++)
            send(1'b1, 32'h0400_0000, 15'(k * 2048 + 1024), 16'sd0, 5'(k + 1),
                16'(k * 1000 - 5000), 17'(k * 6000 - 30000), 16'(k * 4000 - 20000));
        send(1'b0, 32'h0, 15'd20480, 16'sd0, 5'd1, 16'sd0, 17'sd0, 16'sd0);
        send(1'b1, 32'h2000_0000, 15'd2047, 16'sd1, 5'd2, -16'sd1, 17'sd1, 16'sd1);
        send(1'b1, 32'h0000_0001, 15'd10240, 16'sd0, 5'd16, -16'sd20480, -17'sd32768,
            -16'sd20480);

        for (int n = 0; n < 1400; n++)
            send_random();
        op.valid <= 1'b0;
        stim_done = 1'b1;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d requests covering all wave pairs, multiplier and phase wraps,",
            accepted);
        $display("with random gaps on both channels.");
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/mpo_pkg.sv
design/mpo_op_if.sv
design/mpo_res_if.sv
design/mpo_serial_mult.sv
design/morphing_phase_oscillator.sv
verif/mpo_checker.sv
verif/tb_morphing_phase_oscillator.sv
